// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KPTB_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kptb assertion failed");

// next-cycle implication, disabled during reset
`define KPTB_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kptb assertion failed");

`endif

// ===== rtl/kptb_pkg.sv =====
package kptb_pkg;

    // fixed field widths
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = 8;
    localparam int PIX_W       = 16;
    localparam int COORD_W     = 16;
    localparam int ADDR_W      = 25;
    localparam int DIM_W       = 14;
    localparam int PITCH_W     = 15;
    localparam int SUM_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // operation codes
    localparam logic [1:0] OP_PALETTE = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_PIXEL   = 2'd2;

    // result kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // start status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BAD_GEOM = 2'd1;
    localparam logic [1:0] ST_OOB      = 2'd2;

    // blit modes
    localparam logic [1:0] MODE_DIRECT     = 2'd0;
    localparam logic [1:0] MODE_DIRECT_KEY = 2'd1;
    localparam logic [1:0] MODE_INDEXED    = 2'd2;
    localparam logic [1:0] MODE_INDEX_KEY  = 2'd3;

    // transparent palette index in keyed indexed mode
    localparam logic [PAL_AW-1:0] KEY_INDEX = 8'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 3'd4;

    // register reset values
    localparam logic [DIM_W-1:0]   RST_WIDTH  = 14'd320;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 14'd240;
    localparam logic [PITCH_W-1:0] RST_PITCH  = 15'd640;

    // work carried from the decode stage to the output stage
    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [ADDR_W-1:0]  row_base;
        logic [SUM_W-1:0]   col_addr;
        logic [PIX_W-1:0]   pix;
        logic               use_pal;
        logic               wr_en;
        logic               last;
    } kptb_stage_t;

endpackage

// ===== rtl/kptb_if.sv =====
interface kptb_in_if;
    import kptb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [PAL_AW-1:0]         palette_slot;
    logic [PIX_W-1:0]          palette_value;
    logic [PIX_W-1:0]          pixel_data;

    modport source (
        output valid, operation, dest_x, dest_y, palette_slot, palette_value, pixel_data,
        input  ready
    );
    modport sink (
        input  valid, operation, dest_x, dest_y, palette_slot, palette_value, pixel_data,
        output ready
    );
endinterface

interface kptb_out_if;
    import kptb_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [1:0]        status;
    logic [ADDR_W-1:0] write_address;
    logic [PIX_W-1:0]  write_value;
    logic              write_enable;
    logic              last;

    modport source (
        output valid, kind, status, write_address, write_value, write_enable, last,
        input  ready
    );
    modport sink (
        input  valid, kind, status, write_address, write_value, write_enable, last,
        output ready
    );
endinterface

// ===== rtl/kptb_ram.sv =====
module kptb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/kptb_front.sv =====
module kptb_front #(
    parameter int TILE_EXTENT = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                in_valid,
    input  logic [1:0]                          operation,
    input  logic signed [kptb_pkg::COORD_W-1:0] dest_x,
    input  logic signed [kptb_pkg::COORD_W-1:0] dest_y,
    input  logic [kptb_pkg::PIX_W-1:0]          pixel_data,
    input  logic                                cfg_we,
    input  logic [kptb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kptb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                stage_valid,
    output kptb_pkg::kptb_stage_t               stage
);
    import kptb_pkg::*;

    localparam int CNT_W = $clog2(TILE_EXTENT);
    localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(TILE_EXTENT - 1);
    localparam logic [DIM_W-1:0]   TE_DIM   = DIM_W'(TILE_EXTENT);
    localparam logic [COORD_W-1:0] TE_COORD = COORD_W'(TILE_EXTENT);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [1:0]         mode_reg;
    logic [PIX_W-1:0]   key_reg;

    logic [DIM_W-1:0]   origin_x_reg;
    logic [DIM_W-1:0]   origin_y_reg;
    logic [CNT_W-1:0]   row_reg;
    logic [CNT_W-1:0]   col_reg;
    logic               active_reg;
    logic               stage_valid_reg;
    kptb_stage_t        stage_reg;
    kptb_stage_t        stage_next;

    logic               accept;
    logic [DIM_W-1:0]   pitch_words;
    logic               bad_geom;
    logic               out_of_bounds;
    logic [COORD_W-1:0] x_limit;
    logic [COORD_W-1:0] y_limit;
    logic [1:0]         start_status;
    logic               tile_end;
    logic [SUM_W-1:0]   row_sum;
    logic [SUM_W-1:0]   col_sum;
    logic [SUM_W+DIM_W-1:0] row_product;
    logic               pix_en;

    assign accept = in_valid && advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            pitch_reg  <= RST_PITCH;
            mode_reg   <= MODE_DIRECT;
            key_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_PITCH:  pitch_reg  <= cfg_data[PITCH_W-1:0];
                CFG_MODE:   mode_reg   <= cfg_data[1:0];
                CFG_KEY:    key_reg    <= cfg_data[PIX_W-1:0];
                default:    ;
            endcase
        end
    end

    // start checks: geometry first, then tile position
    assign pitch_words = pitch_reg[PITCH_W-1:1];
    assign bad_geom = (pitch_reg == '0) || pitch_reg[0] || (pitch_words < width_reg) ||
                      (width_reg < TE_DIM) || (height_reg < TE_DIM);
    assign x_limit = {{(COORD_W-DIM_W){1'b0}}, width_reg} - TE_COORD;
    assign y_limit = {{(COORD_W-DIM_W){1'b0}}, height_reg} - TE_COORD;
    assign out_of_bounds = dest_x[COORD_W-1] || dest_y[COORD_W-1] ||
                           (COORD_W'(dest_x) > x_limit) || (COORD_W'(dest_y) > y_limit);

    always_comb
    begin
        if (bad_geom)
        begin
            start_status = ST_BAD_GEOM;
        end
        else if (out_of_bounds)
        begin
            start_status = ST_OOB;
        end
        else
        begin
            start_status = ST_DONE;
        end
    end

    // pixel address terms: row base goes through the multiplier
    assign tile_end    = (row_reg == CNT_LAST) && (col_reg == CNT_LAST);
    assign row_sum     = {1'b0, origin_y_reg} + SUM_W'(row_reg);
    assign col_sum     = {1'b0, origin_x_reg} + SUM_W'(col_reg);
    assign row_product = row_sum * pitch_words;

    // write enable from mode and color key
    always_comb
    begin
        case (mode_reg)
            MODE_DIRECT_KEY: pix_en = (pixel_data != key_reg);
            MODE_INDEX_KEY:  pix_en = (pixel_data[PAL_AW-1:0] != KEY_INDEX);
            default:         pix_en = 1'b1;
        endcase
    end

    // stage payload for the next beat
    always_comb
    begin
        stage_next = '0;
        if (operation == OP_START)
        begin
            stage_next.kind   = KIND_STATUS;
            stage_next.status = start_status;
        end
        else
        begin
            stage_next.kind     = KIND_PIXEL;
            stage_next.status   = ST_DONE;
            stage_next.row_base = row_product[ADDR_W-1:0];
            stage_next.col_addr = col_sum;
            stage_next.pix      = pixel_data;
            stage_next.use_pal  = mode_reg[1];
            stage_next.wr_en    = pix_en;
            stage_next.last     = tile_end;
        end
    end

    // tile state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            active_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (operation == OP_START)
            begin
                active_reg <= (start_status == ST_DONE);
                if (start_status == ST_DONE)
                begin
                    origin_x_reg <= dest_x[DIM_W-1:0];
                    origin_y_reg <= dest_y[DIM_W-1:0];
                end
                row_reg <= '0;
                col_reg <= '0;
            end
            else if ((operation == OP_PIXEL) && active_reg)
            begin
                if (tile_end)
                begin
                    active_reg <= 1'b0;
                    row_reg    <= '0;
                    col_reg    <= '0;
                end
                else if (col_reg == CNT_LAST)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= accept &&
                               ((operation == OP_START) || ((operation == OP_PIXEL) && active_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== rtl/kptb_back.sv =====
module kptb_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        stage_valid,
    input  kptb_pkg::kptb_stage_t       stage,
    input  logic [kptb_pkg::PIX_W-1:0]  pal_data,
    output logic                        out_free,
    kptb_out_if.source                  out_ch
);
    import kptb_pkg::*;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [1:0]        status_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PIX_W-1:0]  value_reg;
    logic              enable_reg;
    logic              last_reg;
    logic [PIX_W-1:0]  value_next;
    logic [ADDR_W-1:0] addr_next;

    assign out_free = !out_valid_reg || out_ch.ready;

    // pixel value: palette or direct, zero when skipped
    always_comb
    begin
        if (!stage.wr_en)
        begin
            value_next = '0;
        end
        else if (stage.use_pal)
        begin
            value_next = pal_data;
        end
        else
        begin
            value_next = stage.pix;
        end
    end

    assign addr_next = stage.row_base + {{(ADDR_W-SUM_W){1'b0}}, stage.col_addr};

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            kind_reg   <= stage.kind;
            status_reg <= stage.status;
            addr_reg   <= addr_next;
            value_reg  <= value_next;
            enable_reg <= stage.wr_en;
            last_reg   <= stage.last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.kind          = kind_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.write_address = addr_reg;
    assign out_ch.write_value   = value_reg;
    assign out_ch.write_enable  = enable_reg;
    assign out_ch.last          = last_reg;

endmodule

// ===== rtl/keyed_palette_tile_blitter_top.sv =====
// Keyed palette tile blitter: writes a TILE_EXTENT x TILE_EXTENT tile of 16-bit pixels.
// in_ch takes palette writes, tile starts and source pixels (valid/ready beats);
// out_ch returns one status beat per start and one write beat per pixel of an
// active tile. Palette writes, undefined operations and pixels with no active
// tile return nothing. Surface and mode registers are set through cfg_we /
// cfg_index / cfg_data and take effect for the following beats.
// A result reaches out_ch through the stage register (decode, row multiply and
// palette read) and then the output register (address add).
// Throughput: one input beat per cycle while out_ch does not stall; the palette
// RAM read and the row address multiply share the first stage.
// Reset clears the registers to 320x240, pitch 640, direct mode, key 0, and
// leaves no tile active; the palette is undefined until written.
// When out_ch stalls, the output register and the stage behind it fill, and
// in_ch.ready falls only while both are full; nothing is dropped.
module keyed_palette_tile_blitter_top #(
    parameter int TILE_EXTENT = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kptb_in_if.sink                         in_ch,
    kptb_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [kptb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kptb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kptb_pkg::*;

    logic             advance;
    logic             out_free;
    logic             stage_valid;
    kptb_stage_t      stage;
    logic [PIX_W-1:0] pal_data;
    logic             pal_we;

    // the stage moves when empty or when the output register takes it
    assign advance     = !stage_valid || out_free;
    assign in_ch.ready = advance;
    assign pal_we      = in_ch.valid && advance && (in_ch.operation == OP_PALETTE);

    kptb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PAL_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .we      (pal_we),
        .wr_addr (in_ch.palette_slot),
        .wr_data (in_ch.palette_value),
        .re      (advance),
        .rd_addr (in_ch.pixel_data[PAL_AW-1:0]),
        .rd_data (pal_data)
    );

    kptb_front #(
        .TILE_EXTENT (TILE_EXTENT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_ch.valid),
        .operation   (in_ch.operation),
        .dest_x      (in_ch.dest_x),
        .dest_y      (in_ch.dest_y),
        .pixel_data  (in_ch.pixel_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    kptb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .pal_data    (pal_data),
        .out_free    (out_free),
        .out_ch      (out_ch)
    );

endmodule

// ===== rtl/kptb_checker.sv =====
`include "assert_macros.svh"

module kptb_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         out_kind,
    input  logic [1:0]                   out_status,
    input  logic [kptb_pkg::ADDR_W-1:0]  out_address,
    input  logic [kptb_pkg::PIX_W-1:0]   out_value,
    input  logic                         out_enable,
    input  logic                         out_last
);
    import kptb_pkg::*;

    // a stalled result beat keeps its payload
    `KPTB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_address) && $stable(out_value) && $stable(out_kind))

    // status beats carry no pixel write
    `KPTB_ASSERT_IMPL(a_status_clean, out_valid && (out_kind == KIND_STATUS), (out_address == '0) && (out_value == '0) && !out_enable && !out_last)

    // pixel beats report done status and zero value when skipped
    `KPTB_ASSERT_IMPL(a_pixel_fields, out_valid && (out_kind == KIND_PIXEL), (out_status == ST_DONE) && (out_enable || (out_value == '0)))

    // with the output empty the input side is never held off
    `KPTB_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind keyed_palette_tile_blitter_top kptb_checker u_kptb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_status  (out_ch.status),
    .out_address (out_ch.write_address),
    .out_value   (out_ch.write_value),
    .out_enable  (out_ch.write_enable),
    .out_last    (out_ch.last)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import kptb_pkg::*;

    localparam int TILE         = 16;
    localparam int TILE_PIXELS  = TILE * TILE;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 40;

    // operation code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one beat into the blitter
    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] dest_x;
        logic signed [COORD_W-1:0] dest_y;
        logic [PAL_AW-1:0]         slot;
        logic [PIX_W-1:0]          color;
        logic [PIX_W-1:0]          pix;
    } blit_in_t;

    // one beat out of the blitter
    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  value;
        logic              wr_en;
        logic              last;
    } blit_out_t;

    // surface registers and beat count of one phase
    typedef struct {
        int w;
        int h;
        int pitch;
        int mode;
        int key;
        int items;
    } surface_setup_t;

    // tracks palette, tile position and registers; predicts and checks output beats
    class blit_tracker;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [PITCH_W-1:0] pitch;
        logic [1:0]         mode;
        logic [PIX_W-1:0]   key;
        logic [PIX_W-1:0]   palette [PAL_ENTRIES];
        logic [DIM_W-1:0]   org_x;
        logic [DIM_W-1:0]   org_y;
        int                 row;
        int                 col;
        bit                 active;
        blit_out_t          awaited [$];
        int                 errors;
        int                 n_status;
        int                 n_writes;
        int                 n_skipped;
        int                 n_tiles;

        function new();
            width = RST_WIDTH;
            height = RST_HEIGHT;
            pitch = RST_PITCH;
            mode = MODE_DIRECT;
            key = '0;
            foreach (palette[i])
                palette[i] = '0;
            org_x = '0;
            org_y = '0;
            row = 0;
            col = 0;
            active = 1'b0;
            errors = 0;
            n_status = 0;
            n_writes = 0;
            n_skipped = 0;
            n_tiles = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WIDTH:  width = data[DIM_W-1:0];
                CFG_HEIGHT: height = data[DIM_W-1:0];
                CFG_PITCH:  pitch = data[PITCH_W-1:0];
                CFG_MODE:   mode = data[1:0];
                CFG_KEY:    key = data[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        // pitch zero or odd, row shorter than the surface, or surface smaller than a tile
        function bit geom_bad();
            int words;
            words = int'(pitch >> 1);
            return pitch == 0 || pitch[0] || words < int'(width) ||
                   int'(width) < TILE || int'(height) < TILE;
        endfunction

        function void apply_input(blit_in_t b);
            blit_out_t r;
            int        x;
            int        y;
            logic [PAL_AW-1:0] idx;
            longint    spot;
            r = '0;
            case (b.op)
                OP_PALETTE:
                    palette[b.slot] = b.color;
                OP_START:
                begin
                    x = $signed(b.dest_x);
                    y = $signed(b.dest_y);
                    r.kind = KIND_STATUS;
                    if (geom_bad())
                        r.status = ST_BAD_GEOM;
                    else if (x < 0 || y < 0 || x > int'(width) - TILE ||
                             y > int'(height) - TILE)
                        r.status = ST_OOB;
                    else
                        r.status = ST_DONE;
                    // a start always abandons the running tile
                    active = (r.status == ST_DONE);
                    if (active)
                    begin
                        org_x = b.dest_x[DIM_W-1:0];
                        org_y = b.dest_y[DIM_W-1:0];
                    end
                    row = 0;
                    col = 0;
                    awaited.push_back(r);
                end
                OP_PIXEL:
                    if (active)
                    begin
                        idx = b.pix[PAL_AW-1:0];
                        r.kind = KIND_PIXEL;
                        r.status = ST_DONE;
                        r.wr_en = 1'b1;
                        // word address wraps at the address width
                        spot = (longint'(org_y) + longint'(row)) * longint'(pitch >> 1) +
                               longint'(org_x) + longint'(col);
                        r.addr = spot[ADDR_W-1:0];
                        case (mode)
                            MODE_DIRECT:
                                r.value = b.pix;
                            MODE_DIRECT_KEY:
                            begin
                                r.value = b.pix;
                                r.wr_en = (b.pix != key);
                            end
                            MODE_INDEXED:
                                r.value = palette[idx];
                            default:
                            begin
                                r.value = palette[idx];
                                r.wr_en = (idx != KEY_INDEX);
                            end
                        endcase
                        if (!r.wr_en)
                            r.value = '0;
                        r.last = (row == TILE - 1 && col == TILE - 1);
                        // row-major walk over the tile
                        if (r.last)
                        begin
                            active = 1'b0;
                            row = 0;
                            col = 0;
                        end
                        else if (col == TILE - 1)
                        begin
                            col = 0;
                            row++;
                        end
                        else
                            col++;
                        awaited.push_back(r);
                    end
                default: ;
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %h, expected %h", name, got, want));
        endtask

        task check_output(blit_out_t got);
            blit_out_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("beat with nothing pending: kind %0d addr %h value %h",
                                 got.kind, got.addr, got.value));
                return;
            end
            want = awaited.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("status", got.status, want.status);
            compare_field("write_address", got.addr, want.addr);
            compare_field("write_value", got.value, want.value);
            compare_field("write_enable", got.wr_en, want.wr_en);
            compare_field("last", got.last, want.last);
            if (want.kind == KIND_STATUS)
                n_status++;
            else
            begin
                n_writes++;
                if (!want.wr_en)
                    n_skipped++;
                if (want.last)
                    n_tiles++;
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kptb_in_if  in_ch();
    kptb_out_if out_ch();

    blit_tracker board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pixels_left    = 0;
    int cycle_count    = 0;
    int beats_sent     = 0;

    keyed_palette_tile_blitter_top #(
        .TILE_EXTENT (TILE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // output side: check accepted beats, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_output('{kind: out_ch.kind, status: out_ch.status,
                                 addr: out_ch.write_address, value: out_ch.write_value,
                                 wr_en: out_ch.write_enable, last: out_ch.last});
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d beats pending",
                     cycle_count, board.awaited.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic blit_in_t make_beat(logic [1:0] op, int x, int y, int slot,
                                           int color, int pix);
        blit_in_t b;
        b.op = op;
        b.dest_x = COORD_W'(x);
        b.dest_y = COORD_W'(y);
        b.slot = PAL_AW'(slot);
        b.color = PIX_W'(color);
        b.pix = PIX_W'(pix);
        return b;
    endfunction

    // fields the operation does not use carry noise
    function automatic blit_in_t random_beat(logic [1:0] op);
        return make_beat(op, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic int pick_coord(int hi);
        if (hi < 0)
            hi = 0;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    // fair starts land inside the surface, the rest miss it in assorted ways
    function automatic blit_in_t make_start(bit fair);
        blit_in_t b;
        int       hx;
        int       hy;
        int       x;
        int       y;
        hx = int'(board.width) - TILE;
        hy = int'(board.height) - TILE;
        x = pick_coord(hx);
        y = pick_coord(hy);
        if (!fair)
            case ($urandom_range(0, 5))
                0: x = -1;
                1: x = hx + 1;
                2: y = hy + 1;
                3: x = -32768;
                4: y = 32767;
                default:
                begin
                    x = $urandom;
                    y = $urandom;
                end
            endcase
        b = random_beat(OP_START);
        b.dest_x = COORD_W'(x);
        b.dest_y = COORD_W'(y);
        return b;
    endfunction

    // pixels often hit the key color or the transparent index
    function automatic blit_in_t make_pixel();
        blit_in_t b;
        b = random_beat(OP_PIXEL);
        if ($urandom_range(0, 4) == 0)
        begin
            if (board.mode == MODE_DIRECT_KEY)
                b.pix = board.key;
            else
                b.pix[PAL_AW-1:0] = KEY_INDEX;
        end
        return b;
    endfunction

    function automatic int plan_len();
        if ($urandom_range(0, 99) < 85)
            return TILE_PIXELS;
        return $urandom_range(1, TILE_PIXELS - 1);
    endfunction

    // mostly whole tiles: a start then its pixels, with noise mixed in
    function automatic blit_in_t next_item();
        int       r;
        blit_in_t b;
        r = $urandom_range(0, 99);
        if (pixels_left > 0)
        begin
            if (r < 92)
            begin
                b = make_pixel();
                pixels_left--;
            end
            else if (r < 95)
                b = random_beat(OP_PALETTE);
            else if (r < 97)
                b = random_beat(OP_UNUSED);
            else if (r < 99)
            begin
                b = make_start(1'b1);
                pixels_left = plan_len();
            end
            else
            begin
                b = make_start(1'b0);
                pixels_left = $urandom_range(0, 3);
            end
        end
        else
        begin
            if (r < 70)
            begin
                b = make_start(1'b1);
                pixels_left = plan_len();
            end
            else if (r < 80)
            begin
                b = make_start(1'b0);
                pixels_left = $urandom_range(0, 3);
            end
            else if (r < 88)
                b = make_pixel();
            else if (r < 95)
                b = random_beat(OP_PALETTE);
            else
                b = random_beat(OP_UNUSED);
        end
        return b;
    endfunction

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input blit_in_t b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= b.op;
        in_ch.dest_x        <= b.dest_x;
        in_ch.dest_y        <= b.dest_y;
        in_ch.palette_slot  <= b.slot;
        in_ch.palette_value <= b.color;
        in_ch.pixel_data    <= b.pix;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.apply_input(b);
        beats_sent++;
    endtask

    task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    task automatic configure(input surface_setup_t s);
        drive_reg(CFG_WIDTH, CFG_DATA_W'(s.w));
        drive_reg(CFG_HEIGHT, CFG_DATA_W'(s.h));
        drive_reg(CFG_PITCH, CFG_DATA_W'(s.pitch));
        drive_reg(CFG_MODE, CFG_DATA_W'(s.mode));
        drive_reg(CFG_KEY, CFG_DATA_W'(s.key));
        cfg_we <= 1'b0;
    endtask

    // wait out pending beats plus the pipeline depth
    task automatic settle();
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // reset registers: 320x240, pitch 640, direct, key 0
    task automatic run_directed();
        send_beat(make_beat(OP_UNUSED, -1, -1, 255, 16'hFFFF, 16'hFFFF));
        send_beat(make_beat(OP_PIXEL, 0, 0, 0, 0, 16'hFFFF));
        send_beat(make_beat(OP_PALETTE, 0, 0, 0, 16'hFFFF, 0));
        send_beat(make_beat(OP_PALETTE, 0, 0, 255, 16'h0000, 0));
        send_beat(make_beat(OP_PALETTE, 0, 0, 1, 16'hA5A5, 0));
        send_beat(make_beat(OP_START, -1, 0, 0, 0, 0));
        send_beat(make_beat(OP_START, 0, -32768, 0, 0, 0));
        send_beat(make_beat(OP_START, 32767, 32767, 0, 0, 0));
        send_beat(make_beat(OP_START, 305, 0, 0, 0, 0));
        send_beat(make_beat(OP_START, 0, 225, 0, 0, 0));
        send_beat(make_beat(OP_PIXEL, 0, 0, 0, 0, 16'h1234));
        send_beat(make_beat(OP_START, 304, 224, 0, 0, 0));
        send_beat(make_beat(OP_PIXEL, 0, 0, 0, 0, 16'h0000));
        send_beat(make_beat(OP_PIXEL, 0, 0, 0, 0, 16'hFFFF));
        send_beat(make_beat(OP_PIXEL, 0, 0, 0, 0, 16'h8001));
        // restart in the middle of a tile
        send_beat(make_beat(OP_START, 0, 0, 0, 0, 0));
        send_beat(make_beat(OP_PIXEL, 0, 0, 0, 0, 16'h7FFE));
        send_beat(make_beat(OP_PIXEL, 0, 0, 0, 0, 16'h5555));
        // failing start drops the tile
        send_beat(make_beat(OP_START, -32768, -32768, 0, 0, 0));
        send_beat(make_beat(OP_PIXEL, 0, 0, 0, 0, 16'hAAAA));
        send_beat(make_beat(OP_UNUSED, 0, 0, 0, 0, 0));
        in_ch.valid <= 1'b0;
    endtask

    // every palette entry is written before any indexed pixel
    task automatic fill_palette();
        int slot;
        for (slot = 0; slot < PAL_ENTRIES; slot++)
            send_beat(make_beat(OP_PALETTE, $urandom, $urandom, slot, $urandom, $urandom));
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        surface_setup_t plan [$];
        surface_setup_t s;
        int             k;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.operation     = OP_PALETTE;
        in_ch.dest_x        = '0;
        in_ch.dest_y        = '0;
        in_ch.palette_slot  = '0;
        in_ch.palette_value = '0;
        in_ch.pixel_data    = '0;

        // valid geometry: smallest surface, large, largest with address wrap, row == width
        plan.push_back('{16, 16, 32, MODE_DIRECT_KEY, 0, 250});
        plan.push_back('{8192, 8192, 16384, MODE_INDEXED, 16'hFFFF, 250});
        plan.push_back('{16383, 16383, 32766, MODE_INDEX_KEY, 16'h1234, 250});
        // invalid geometry: odd pitch, zero surface, zero pitch, short, narrow row
        plan.push_back('{320, 240, 641, MODE_DIRECT, 16'h8000, 40});
        plan.push_back('{0, 0, 32767, MODE_INDEX_KEY, 16'h0001, 30});
        plan.push_back('{15, 240, 0, MODE_INDEXED, 16'h7FFF, 30});
        plan.push_back('{320, 15, 640, MODE_DIRECT_KEY, 16'h00FF, 30});
        plan.push_back('{400, 300, 798, MODE_DIRECT, 16'hFF00, 30});
        plan.push_back('{100, 50, 200, MODE_DIRECT_KEY, 16'hFFFF, 250});
        for (k = 0; k < 2; k++)
        begin
            s.w = $urandom_range(TILE, 1200);
            s.h = $urandom_range(TILE, 1200);
            s.pitch = 2 * $urandom_range(s.w, s.w + 40);
            s.mode = (k == 0) ? int'(MODE_DIRECT) : int'($urandom_range(0, 3));
            s.key = $urandom_range(0, 65535);
            s.items = 250;
            plan.push_back(s);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        fill_palette();

        for (k = 0; k < plan.size(); k++)
        begin
            settle();
            // idling pattern rotates over the phases
            case (k % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct = 27;
                    recv_stall_pct = 27;
                end
            endcase
            configure(plan[k]);
            pixels_left = 0;
            repeat (plan[k].items) send_beat(next_item());
            in_ch.valid <= 1'b0;
        end
        settle();

        $display("sent %0d input beats over %0d surface setups and all four blit modes",
                 beats_sent, plan.size() + 1);
        $display("checked %0d status beats, %0d pixel writes (%0d transparent), %0d tiles",
                 board.n_status, board.n_writes, board.n_skipped, board.n_tiles);
        if (board.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
